// ===== rtl/core/point_to_occupancy_grid_unit_defines.svh =====
// assertion macros shared by the occupancy grid rtl
`ifndef POINT_TO_OCCUPANCY_GRID_UNIT_DEFINES_SVH
`define POINT_TO_OCCUPANCY_GRID_UNIT_DEFINES_SVH

// same-cycle implication check
`define P2OG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("occupancy grid check failed");

// next-cycle implication check
`define P2OG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("occupancy grid check failed");

`endif

// ===== rtl/core/p2og_pkg.sv =====
// types, constants and register codes of the occupancy grid unit
`timescale 1ns / 1ps
package p2og_pkg;

   localparam int MAX_COLUMNS_DEF = 256;
   localparam int MAX_ROWS_DEF    = 256;
   localparam int COORD_BITS_DEF  = 16;

   localparam int EXTENT_W    = 15;
   localparam int CELL_SIZE_W = 13;
   localparam int HEIGHT_W    = 16;
   localparam int GRID_W      = 9;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam int NUM_W       = 16;
   localparam int DIV_W       = CELL_SIZE_W;
   localparam int CELL_W      = 16;
   localparam int WORD_W      = 64;
   localparam int WORD_ADDR_W = 10;
   localparam int BITMAP_WORDS = 1 << WORD_ADDR_W;
   localparam int BIT_SEL_W   = 6;
   localparam int STATUS_W    = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_SIZE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_Z        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_Z        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLUMNS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS    = 3'd6;

   localparam logic [EXTENT_W-1:0]    HALF_WIDTH_RST   = 15'd5000;
   localparam logic [EXTENT_W-1:0]    HALF_HEIGHT_RST  = 15'd5000;
   localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST    = 13'd50;
   localparam logic [HEIGHT_W-1:0]    MIN_Z_RST        = 16'hFF9C;
   localparam logic [HEIGHT_W-1:0]    MAX_Z_RST        = 16'd100;
   localparam logic [GRID_W-1:0]      GRID_COLUMNS_RST = 9'd200;
   localparam logic [GRID_W-1:0]      GRID_ROWS_RST    = 9'd200;

   typedef enum logic [STATUS_W-1:0] {
      ST_MARKED  = 3'd0,
      ST_INVALID = 3'd1,
      ST_HEIGHT  = 3'd2,
      ST_EXTENT  = 3'd3,
      ST_READ    = 3'd4
   } status_type;

   typedef struct packed {
      logic [EXTENT_W-1:0]    half_width;
      logic [EXTENT_W-1:0]    half_height;
      logic [CELL_SIZE_W-1:0] cell_size;
      logic [HEIGHT_W-1:0]    min_z;
      logic [HEIGHT_W-1:0]    max_z;
      logic [GRID_W-1:0]      grid_columns;
      logic [GRID_W-1:0]      grid_rows;
   } cfg_type;

   typedef struct packed {
      status_type             status;
      logic [CELL_W-1:0]      index;
      logic [WORD_ADDR_W-1:0] addr;
   } queue_entry_type;

endpackage

// ===== rtl/core/point_to_occupancy_grid_unit.sv =====
// Point to occupancy grid unit: projects lidar points onto a 2-D occupancy
// bitmap of 1024 x 64 cells and hands out read-and-clear bitmap words. After
// reset the bitmap is swept clear word by word, during which req_ready stays
// low (register writes are taken). A read or a rejected point passes through
// the queue, stage one and the result register; the back end issues an item
// only with stage one empty, after the previous read-modify-write of the
// bitmap memory. A marked point holds the front end while the bit-serial
// divider forms column and row, then for clamp, multiply and queue push.
// A 4-entry queue separates front and back and lets new items be taken while
// a result waits on rsp_ready, though the back end issues none until it goes.
`timescale 1ns / 1ps
module point_to_occupancy_grid_unit #(
   parameter int MAX_COLUMNS = p2og_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = p2og_pkg::MAX_ROWS_DEF,
   parameter int COORD_BITS  = p2og_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [p2og_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [p2og_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic signed [COORD_BITS-1:0]      req_point_x,
   input  logic signed [COORD_BITS-1:0]      req_point_y,
   input  logic signed [COORD_BITS-1:0]      req_point_z,
   input  logic                              req_point_valid,
   input  logic [p2og_pkg::WORD_ADDR_W-1:0]  req_word_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [p2og_pkg::STATUS_W-1:0]     rsp_status,
   output logic [p2og_pkg::CELL_W-1:0]       rsp_cell_index,
   output logic [p2og_pkg::WORD_W-1:0]       rsp_read_word
);
   import p2og_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            clearing;
   logic            q_push, q_full, q_pop, q_valid;
   queue_entry_type q_push_entry, q_pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:   cfg_in.half_width   = csr_data[EXTENT_W-1:0];
            CSR_HALF_HEIGHT:  cfg_in.half_height  = csr_data[EXTENT_W-1:0];
            CSR_CELL_SIZE:    cfg_in.cell_size    = csr_data[CELL_SIZE_W-1:0];
            CSR_MIN_Z:        cfg_in.min_z        = csr_data[HEIGHT_W-1:0];
            CSR_MAX_Z:        cfg_in.max_z        = csr_data[HEIGHT_W-1:0];
            CSR_GRID_COLUMNS: cfg_in.grid_columns = csr_data[GRID_W-1:0];
            CSR_GRID_ROWS:    cfg_in.grid_rows    = csr_data[GRID_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{half_width:   HALF_WIDTH_RST,
                     half_height:  HALF_HEIGHT_RST,
                     cell_size:    CELL_SIZE_RST,
                     min_z:        MIN_Z_RST,
                     max_z:        MAX_Z_RST,
                     grid_columns: GRID_COLUMNS_RST,
                     grid_rows:    GRID_ROWS_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   p2og_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .clearing         (clearing),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_point_valid  (req_point_valid),
      .req_word_address (req_word_address),
      .q_push           (q_push),
      .q_entry          (q_push_entry),
      .q_full           (q_full)
   );

   p2og_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_entry),
      .not_empty (q_valid)
   );

   p2og_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_pop_entry),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_cell_index (rsp_cell_index),
      .rsp_read_word  (rsp_read_word)
   );

endmodule

// ===== rtl/core/p2og_div.sv =====
// bit-serial restoring divider, column and row quotients side by side
`timescale 1ns / 1ps
module p2og_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [p2og_pkg::NUM_W-1:0]    num_col,
   input  logic [p2og_pkg::NUM_W-1:0]    num_row,
   input  logic [p2og_pkg::DIV_W-1:0]    divisor,
   output logic                          done,
   output logic [p2og_pkg::NUM_W-1:0]    quot_col,
   output logic [p2og_pkg::NUM_W-1:0]    quot_row
);
   import p2og_pkg::*;

   localparam int STEP_W = $clog2(NUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  dv_ff, dv_in;
   logic [DIV_W-1:0]  rem_col_ff, rem_col_in, rem_row_ff, rem_row_in;
   logic [NUM_W-1:0]  quo_col_ff, quo_col_in, quo_row_ff, quo_row_in;
   logic [DIV_W:0]    res_col, res_row;

   // returns {new remainder, quotient bit}
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                               input logic lead,
                                               input logic [DIV_W-1:0] dv);
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      trial = {rem, lead};
      diff  = trial - {1'b0, dv};
      if (trial >= {1'b0, dv}) begin
         div_step = {diff[DIV_W-1:0], 1'b1};
      end else begin
         div_step = {trial[DIV_W-1:0], 1'b0};
      end
   endfunction

   assign res_col = div_step(rem_col_ff, quo_col_ff[NUM_W-1], dv_ff);
   assign res_row = div_step(rem_row_ff, quo_row_ff[NUM_W-1], dv_ff);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      dv_in      = dv_ff;
      rem_col_in = rem_col_ff;
      rem_row_in = rem_row_ff;
      quo_col_in = quo_col_ff;
      quo_row_in = quo_row_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         dv_in      = divisor;
         rem_col_in = '0;
         rem_row_in = '0;
         quo_col_in = num_col;
         quo_row_in = num_row;
      end else if (busy_ff) begin
         rem_col_in = res_col[DIV_W:1];
         rem_row_in = res_row[DIV_W:1];
         // dividend bits shift out the top while quotient bits shift in
         quo_col_in = {quo_col_ff[NUM_W-2:0], res_col[0]};
         quo_row_in = {quo_row_ff[NUM_W-2:0], res_row[0]};
         step_in    = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff      <= dv_in;
      rem_col_ff <= rem_col_in;
      rem_row_ff <= rem_row_in;
      quo_col_ff <= quo_col_in;
      quo_row_ff <= quo_row_in;
   end

   assign done     = done_ff;
   assign quot_col = quo_col_ff;
   assign quot_row = quo_row_ff;

endmodule

// ===== rtl/core/p2og_front.sv =====
// front end: accepts items, classifies points and projects them onto the grid
`timescale 1ns / 1ps
module p2og_front #(
   parameter int MAX_COLUMNS = p2og_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = p2og_pkg::MAX_ROWS_DEF,
   parameter int COORD_BITS  = p2og_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  p2og_pkg::cfg_type                   cfg,
   input  logic                                clearing,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [COORD_BITS-1:0]        req_point_x,
   input  logic signed [COORD_BITS-1:0]        req_point_y,
   input  logic signed [COORD_BITS-1:0]        req_point_z,
   input  logic                                req_point_valid,
   input  logic [p2og_pkg::WORD_ADDR_W-1:0]    req_word_address,
   output logic                                q_push,
   output p2og_pkg::queue_entry_type           q_entry,
   input  logic                                q_full
);
   import p2og_pkg::*;

   localparam int EXT_W     = ((COORD_BITS > HEIGHT_W) ? COORD_BITS : HEIGHT_W) + 2;
   localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int COL_IDX_W = $clog2(MAX_COLUMNS);
   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int ROW_IDX_W = $clog2(MAX_ROWS);
   localparam int CSAT_W    = (COL_CNT_W > GRID_W) ? COL_CNT_W : GRID_W;
   localparam int RSAT_W    = (ROW_CNT_W > GRID_W) ? ROW_CNT_W : GRID_W;
   localparam int PROD_W    = COL_CNT_W + ROW_IDX_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int IDX_EXT_W = (SUM_W > CELL_W) ? SUM_W : CELL_W;

   typedef enum logic [4:0] {
      FR_IDLE   = 5'b00001,
      FR_DIVIDE = 5'b00010,
      FR_CLAMP  = 5'b00100,
      FR_MULT   = 5'b01000,
      FR_PUSH   = 5'b10000
   } front_state_type;

   front_state_type        state_ff, state_in;
   logic [COL_IDX_W-1:0]   col_ff, col_in;
   logic [ROW_IDX_W-1:0]   row_ff, row_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;

   logic signed [EXT_W-1:0] x_ext, y_ext, z_ext, abs_x, abs_y;
   logic signed [EXT_W-1:0] hw_ext, hh_ext, min_ext, max_ext;
   logic signed [EXT_W-1:0] num_col_full, num_row_full;
   logic                    height_bad, extent_bad, accept, div_start, div_done;
   logic [DIV_W-1:0]        cs;
   logic [NUM_W-1:0]        quot_col, quot_row;
   logic [CSAT_W-1:0]       gc_ext;
   logic [RSAT_W-1:0]       gr_ext;
   logic [COL_CNT_W-1:0]    cols;
   logic [ROW_CNT_W-1:0]    rows;
   logic [COL_IDX_W-1:0]    col_lim;
   logic [ROW_IDX_W-1:0]    row_lim;
   logic [IDX_EXT_W-1:0]    index_sum;
   logic [CELL_W-1:0]       cell_index;

   assign x_ext   = EXT_W'(req_point_x);
   assign y_ext   = EXT_W'(req_point_y);
   assign z_ext   = EXT_W'(req_point_z);
   assign abs_x   = x_ext[EXT_W-1] ? -x_ext : x_ext;
   assign abs_y   = y_ext[EXT_W-1] ? -y_ext : y_ext;
   assign hw_ext  = EXT_W'({1'b0, cfg.half_width});
   assign hh_ext  = EXT_W'({1'b0, cfg.half_height});
   assign min_ext = EXT_W'($signed(cfg.min_z));
   assign max_ext = EXT_W'($signed(cfg.max_z));

   // an inverted height window rejects every valid point here
   assign height_bad = (z_ext > max_ext) || (z_ext < min_ext);
   assign extent_bad = (abs_x >= hh_ext) || (abs_y >= hw_ext);

   // both numerators are positive and below 2^16 for in-extent points
   assign num_col_full = hw_ext - y_ext;
   assign num_row_full = hh_ext + x_ext;
   assign cs = (cfg.cell_size == '0) ? DIV_W'(1) : cfg.cell_size;

   assign gc_ext = CSAT_W'(cfg.grid_columns);
   assign gr_ext = RSAT_W'(cfg.grid_rows);
   assign cols = (gc_ext == '0) ? COL_CNT_W'(1) :
                 (gc_ext > CSAT_W'(MAX_COLUMNS)) ? COL_CNT_W'(MAX_COLUMNS) :
                 COL_CNT_W'(gc_ext);
   assign rows = (gr_ext == '0) ? ROW_CNT_W'(1) :
                 (gr_ext > RSAT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS) :
                 ROW_CNT_W'(gr_ext);
   assign col_lim = COL_IDX_W'(cols - COL_CNT_W'(1));
   assign row_lim = ROW_IDX_W'(rows - ROW_CNT_W'(1));

   assign index_sum  = IDX_EXT_W'(prod_ff) + IDX_EXT_W'(col_ff);
   assign cell_index = index_sum[CELL_W-1:0];

   assign req_ready = (state_ff == FR_IDLE) && !q_full && !clearing;
   assign accept    = req_valid && req_ready;

   p2og_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_col  (num_col_full[NUM_W-1:0]),
      .num_row  (num_row_full[NUM_W-1:0]),
      .divisor  (cs),
      .done     (div_done),
      .quot_col (quot_col),
      .quot_row (quot_row)
   );

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      prod_in   = prod_ff;
      div_start = 1'b0;
      q_push    = 1'b0;
      q_entry   = '{status: ST_INVALID, index: '0, addr: '0};
      unique case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               priority if (req_operation == OP_READ) begin
                  q_push         = 1'b1;
                  q_entry.status = ST_READ;
                  q_entry.addr   = req_word_address;
               end else if (!req_point_valid) begin
                  q_push         = 1'b1;
                  q_entry.status = ST_INVALID;
               end else if (height_bad) begin
                  q_push         = 1'b1;
                  q_entry.status = ST_HEIGHT;
               end else if (extent_bad) begin
                  q_push         = 1'b1;
                  q_entry.status = ST_EXTENT;
               end else begin
                  div_start = 1'b1;
                  state_in  = FR_DIVIDE;
               end
            end
         end
         FR_DIVIDE: begin
            if (div_done) begin
               state_in = FR_CLAMP;
            end
         end
         FR_CLAMP: begin
            // cells past the grid saturate to the last column and row
            col_in   = (quot_col > NUM_W'(col_lim)) ? col_lim : COL_IDX_W'(quot_col);
            row_in   = (quot_row > NUM_W'(row_lim)) ? row_lim : ROW_IDX_W'(quot_row);
            state_in = FR_MULT;
         end
         FR_MULT: begin
            prod_in  = PROD_W'(cols) * PROD_W'(row_ff);
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (!q_full) begin
               q_push         = 1'b1;
               q_entry.status = ST_MARKED;
               q_entry.index  = cell_index;
               q_entry.addr   = cell_index[CELL_W-1:BIT_SEL_W];
               state_in       = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      row_ff  <= row_in;
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/p2og_fifo.sv =====
// short queue of classified items between front and back
`timescale 1ns / 1ps
`include "point_to_occupancy_grid_unit_defines.svh"
module p2og_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  p2og_pkg::queue_entry_type  push_data,
   output logic                       full,
   input  logic                       pop,
   output p2og_pkg::queue_entry_type  pop_data,
   output logic                       not_empty
);
   import p2og_pkg::*;

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `P2OG_ASSERT_SAME(a_no_overflow, clock, reset, push, !full)
   `P2OG_ASSERT_SAME(a_no_underflow, clock, reset, pop, not_empty)
   `P2OG_ASSERT_SAME(a_full_has_data, clock, reset, full, not_empty)

endmodule

// ===== rtl/core/p2og_back.sv =====
// back end: bitmap read-modify-write, read-and-clear and result register
`timescale 1ns / 1ps
`include "point_to_occupancy_grid_unit_defines.svh"
module p2og_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  p2og_pkg::queue_entry_type        q_entry,
   output logic                             q_pop,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [p2og_pkg::STATUS_W-1:0]    rsp_status,
   output logic [p2og_pkg::CELL_W-1:0]      rsp_cell_index,
   output logic [p2og_pkg::WORD_W-1:0]      rsp_read_word
);
   import p2og_pkg::*;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'b01,
      BK_RUN   = 2'b10
   } back_state_type;

   logic [WORD_W-1:0]      bitmap [BITMAP_WORDS];

   back_state_type         state_ff, state_in;
   logic [WORD_ADDR_W-1:0] clr_ff, clr_in;
   logic                   s1_valid_ff, s1_valid_in;
   queue_entry_type        s1_entry_ff;
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff;
   logic [CELL_W-1:0]      rsp_index_ff;
   logic [WORD_W-1:0]      rsp_word_ff;

   logic                   mem_we;
   logic [WORD_ADDR_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0]      mem_wr_data;
   logic                   s1_read, s1_mark;

   assign clearing = (state_ff == BK_CLEAR);

   // issue only with stage one empty, so the previous write has landed
   assign q_pop = (state_ff == BK_RUN) && q_valid && !s1_valid_ff &&
                  (!rsp_valid_ff || rsp_ready);

   assign s1_read = s1_valid_ff && (s1_entry_ff.status == ST_READ);
   assign s1_mark = s1_valid_ff && (s1_entry_ff.status == ST_MARKED);

   always_comb begin
      mem_we      = clearing || s1_read || s1_mark;
      mem_wr_addr = clearing ? clr_ff : s1_entry_ff.addr;
      mem_wr_data = '0;
      if (s1_mark) begin
         mem_wr_data = rd_data_ff |
                       (WORD_W'(1) << s1_entry_ff.index[BIT_SEL_W-1:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      if (clearing) begin
         clr_in = clr_ff + WORD_ADDR_W'(1);
         if (clr_ff == '1) begin
            state_in = BK_RUN;
         end
      end
      s1_valid_in  = q_pop;
      rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap[mem_wr_addr] <= mem_wr_data;
      end
      if (q_pop) begin
         rd_data_ff <= bitmap[q_entry.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_entry_ff <= q_entry;
      end
      if (s1_valid_ff) begin
         rsp_status_ff <= s1_entry_ff.status;
         rsp_index_ff  <= s1_entry_ff.index;
         rsp_word_ff   <= s1_read ? rd_data_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_index = rsp_index_ff;
   assign rsp_read_word  = rsp_word_ff;

   `P2OG_ASSERT_NEXT(a_stage_one_cycle, clock, reset, s1_valid_ff, !s1_valid_ff)
   `P2OG_ASSERT_SAME(a_no_issue_in_clear, clock, reset, clearing, !q_pop)
   `P2OG_ASSERT_SAME(a_result_slot_free, clock, reset, s1_valid_ff, !rsp_valid_ff || rsp_ready)

endmodule

// ===== verif/point_to_occupancy_grid_unit_test.sv =====
// self-checking testbench for the point to occupancy grid unit
`timescale 1ns / 1ps
module point_to_occupancy_grid_unit_test;
   import p2og_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int PHASES = 12;
   localparam int POINTS_PER_PHASE = 150;

   typedef struct packed {
      logic                   operation;
      logic signed [CB-1:0]   x;
      logic signed [CB-1:0]   y;
      logic signed [CB-1:0]   z;
      logic                   point_valid;
      logic [WORD_ADDR_W-1:0] word_address;
   } point_type;

   typedef struct packed {
      status_type        status;
      logic [CELL_W-1:0] cell_index;
      logic [WORD_W-1:0] read_word;
   } grid_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HALF_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = OP_ADD;
   logic signed [CB-1:0] req_point_x = '0;
   logic signed [CB-1:0] req_point_y = '0;
   logic signed [CB-1:0] req_point_z = '0;
   logic req_point_valid = 1'b0;
   logic [WORD_ADDR_W-1:0] req_word_address = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [CELL_W-1:0] rsp_cell_index;
   logic [WORD_W-1:0] rsp_read_word;

   // shadow of the registers and the bitmap
   cfg_type grid_cfg;
   logic [WORD_W-1:0] occupancy_copy [BITMAP_WORDS];
   logic [WORD_ADDR_W-1:0] marked_words [$];

   point_type points_to_send [$];
   grid_result_type cell_results_due [$];
   point_type offered;
   point_type next_point;
   grid_result_type got;
   grid_result_type want;

   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int status_count [5] = '{0, 0, 0, 0, 0};
   int nonempty_reads = 0;
   int tick_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic quiet_stretch;

   point_to_occupancy_grid_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_point_valid  (req_point_valid),
      .req_word_address (req_word_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_read_word    (rsp_read_word)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      tick_count <= tick_count + 1;
   end

   // no random idling on either side during this window
   assign quiet_stretch = (tick_count % 5000) < 1200;

   function automatic grid_result_type project_point(point_type pt);
      grid_result_type r;
      int x, y, z, lo, hi, hw, hh, cs, cols, rows, col, row, ax, ay;
      logic [CELL_W-1:0] cell_no;
      r.status = ST_READ;
      r.cell_index = '0;
      r.read_word = '0;
      if (pt.operation == OP_READ) begin
         r.read_word = occupancy_copy[pt.word_address];
         occupancy_copy[pt.word_address] = '0;
         return r;
      end
      x = $signed(pt.x);
      y = $signed(pt.y);
      z = $signed(pt.z);
      lo = $signed(grid_cfg.min_z);
      hi = $signed(grid_cfg.max_z);
      hw = grid_cfg.half_width;
      hh = grid_cfg.half_height;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (!pt.point_valid) begin
         r.status = ST_INVALID;
      end else if (z > hi || z < lo) begin
         r.status = ST_HEIGHT;
      end else if (ax >= hh || ay >= hw) begin
         r.status = ST_EXTENT;
      end else begin
         cs = (grid_cfg.cell_size == 0) ? 1 : grid_cfg.cell_size;
         cols = (grid_cfg.grid_columns == 0) ? 1 : grid_cfg.grid_columns;
         rows = (grid_cfg.grid_rows == 0) ? 1 : grid_cfg.grid_rows;
         if (cols > MAX_COLUMNS_DEF) cols = MAX_COLUMNS_DEF;
         if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
         col = (hw - y) / cs;
         row = (hh + x) / cs;
         if (col > cols - 1) col = cols - 1;
         if (row > rows - 1) row = rows - 1;
         cell_no = CELL_W'(col + cols * row);
         occupancy_copy[cell_no[15:6]] |= 64'd1 << cell_no[5:0];
         marked_words.push_back(cell_no[15:6]);
         if (marked_words.size() > 64) void'(marked_words.pop_front());
         r.status = ST_MARKED;
         r.cell_index = cell_no;
      end
      return r;
   endfunction

   // mostly well-formed points, some reads aimed at recently marked words
   function automatic point_type random_point();
      point_type pt;
      int lo, hi, hh, hw, pick;
      pt.operation = OP_ADD;
      pt.x = CB'($urandom());
      pt.y = CB'($urandom());
      pt.z = CB'($urandom());
      pt.point_valid = 1'b1;
      pt.word_address = WORD_ADDR_W'($urandom());
      pick = $urandom_range(0, 99);
      lo = $signed(grid_cfg.min_z);
      hi = $signed(grid_cfg.max_z);
      hh = grid_cfg.half_height;
      hw = grid_cfg.half_width;
      if (pick < 20) begin
         pt.operation = OP_READ;
         if (marked_words.size() != 0 && $urandom_range(0, 1) == 1)
            pt.word_address = marked_words[$urandom_range(0, marked_words.size() - 1)];
      end else if (pick < 28) begin
         pt.point_valid = 1'b0;
      end else if (pick < 90) begin
         if (lo <= hi) pt.z = CB'(lo + int'($urandom_range(0, hi - lo)));
         if (hh > 0) pt.x = CB'(int'($urandom_range(0, 2 * hh - 2)) - (hh - 1));
         if (hw > 0) pt.y = CB'(int'($urandom_range(0, 2 * hw - 2)) - (hw - 1));
      end
      return pt;
   endfunction

   task automatic queue_point(point_type pt);
      while (points_to_send.size() >= 4) @(negedge clock);
      points_to_send.push_back(pt);
   endtask

   task automatic wait_until_idle();
      while (points_to_send.size() != 0 || req_valid || cell_results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      case (idx)
         CSR_HALF_WIDTH:   grid_cfg.half_width = value[14:0];
         CSR_HALF_HEIGHT:  grid_cfg.half_height = value[14:0];
         CSR_CELL_SIZE:    grid_cfg.cell_size = value[12:0];
         CSR_MIN_Z:        grid_cfg.min_z = value[15:0];
         CSR_MAX_Z:        grid_cfg.max_z = value[15:0];
         CSR_GRID_COLUMNS: grid_cfg.grid_columns = value[8:0];
         CSR_GRID_ROWS:    grid_cfg.grid_rows = value[8:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(int hw, int hh, int cs, int lo, int hi, int cols, int rows);
      write_register(CSR_HALF_WIDTH, hw);
      write_register(CSR_HALF_HEIGHT, hh);
      write_register(CSR_CELL_SIZE, cs);
      write_register(CSR_MIN_Z, lo);
      write_register(CSR_MAX_Z, hi);
      write_register(CSR_GRID_COLUMNS, cols);
      write_register(CSR_GRID_ROWS, rows);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cell_results_due.push_back(project_point(offered));
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (points_to_send.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 21)) begin
               next_point = points_to_send.pop_front();
               offered = next_point;
               req_operation <= next_point.operation;
               req_point_x <= next_point.x;
               req_point_y <= next_point.y;
               req_point_z <= next_point.z;
               req_point_valid <= next_point.point_valid;
               req_word_address <= next_point.word_address;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = status_type'(rsp_status);
         got.cell_index = rsp_cell_index;
         got.read_word = rsp_read_word;
         results_seen++;
         if (cell_results_due.size() == 0) begin
            $error("result transfer with no item outstanding: status %0d", rsp_status);
            failures++;
         end else begin
            want = cell_results_due.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (got.cell_index !== want.cell_index) begin
               $error("cell_index: expected %0d, got %0d", want.cell_index, got.cell_index);
               failures++;
            end
            if (got.read_word !== want.read_word) begin
               $error("read_word: expected %h, got %h", want.read_word, got.read_word);
               failures++;
            end
            if (want.status <= ST_READ) status_count[want.status]++;
            if (want.status == ST_READ && want.read_word != 0) nonempty_reads++;
         end
      end
      // one long hold-off so the queue fills and req_ready drops
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 600) begin
         rsp_ready <= 1'b0;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= quiet_stretch || ($urandom_range(0, 99) >= 21);
      end
   end

   initial begin
      #6_000_000;
      $display("[point_to_occupancy_grid_unit] ERROR");
      $finish;
   end

   initial begin
      int hw, hh, cs;
      grid_cfg.half_width = HALF_WIDTH_RST;
      grid_cfg.half_height = HALF_HEIGHT_RST;
      grid_cfg.cell_size = CELL_SIZE_RST;
      grid_cfg.min_z = MIN_Z_RST;
      grid_cfg.max_z = MAX_Z_RST;
      grid_cfg.grid_columns = GRID_COLUMNS_RST;
      grid_cfg.grid_rows = GRID_ROWS_RST;
      for (int i = 0; i < BITMAP_WORDS; i++) occupancy_copy[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset settings
      queue_point('{OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, 10'd1023});
      queue_point('{OP_ADD, 16'sd0, 16'sd0, 16'sd101, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, 16'sd0, -16'sd101, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, 16'sd0, 16'sd32767, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, 16'sd0, -16'sd32768, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd20000, 16'sd0, 16'sd500, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd5000, 16'sd0, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, -16'sd5000, 16'sd0, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, 16'sd5000, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, -16'sd5000, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, -16'sd32768, 16'sd0, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, -16'sd32768, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd4999, 16'sd4999, 16'sd100, 1'b1, 10'd0});
      queue_point('{OP_ADD, -16'sd4999, -16'sd4999, -16'sd100, 1'b1, 10'd0});
      queue_point('{OP_ADD, 16'sd0, 16'sd0, 16'sd0, 1'b1, 10'd1023});
      queue_point('{OP_ADD, 16'sd1, 16'sd1, 16'sd0, 1'b1, 10'd0});
      queue_point('{OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b1, 10'd621});
      queue_point('{OP_READ, -16'sd1, -16'sd1, -16'sd1, 1'b0, 10'd3});
      queue_point('{OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b1, 10'd314});
      queue_point('{OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b1, 10'd621});
      queue_point('{OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b1, 10'd1023});

      for (int p = 0; p < PHASES; p++) begin
         wait_until_idle();
         hw = $urandom_range(50, 8000);
         hh = $urandom_range(50, 8000);
         cs = $urandom_range(1, 400);
         case (p)
            0: apply_settings(32767, 32767, 4096, -32768, 32767, 256, 256);
            1: apply_settings(1, 1, 1, 0, 0, 1, 1);
            // zero cell size, zero columns, oversized rows
            2: apply_settings(3000, 3000, 0, -300, 300, 0, 511);
            // inverted height window
            3: apply_settings(hw, hh, cs, 100, -100, 200, 200);
            // zero half extents
            4: apply_settings(0, 0, cs, -1000, 1000, 100, 100);
            5: apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom());
            11: apply_settings(5000, 5000, 50, -100, 100, 200, 200);
            default: apply_settings(hw, hh, cs, -int'($urandom_range(0, 2000)),
                                    $urandom_range(0, 2000),
                                    $urandom_range(1, 2 * hw / cs + 2),
                                    $urandom_range(1, 2 * hh / cs + 2));
         endcase
         for (int i = 0; i < POINTS_PER_PHASE; i++) queue_point(random_point());
      end

      wait_until_idle();
      repeat (60) @(posedge clock);
      $display("covered %0d transfers over %0d register settings plus reset values",
               items_sent, PHASES);
      $display("marked %0d, invalid %0d, height %0d, extent %0d, reads %0d (%0d nonempty)",
               status_count[ST_MARKED], status_count[ST_INVALID], status_count[ST_HEIGHT],
               status_count[ST_EXTENT], status_count[ST_READ], nonempty_reads);
      if (failures == 0) begin
         $display("[point_to_occupancy_grid_unit] OK");
      end else begin
         $display("[point_to_occupancy_grid_unit] ERROR");
      end
      $finish;
   end

endmodule
